// ===== src/graphql_token_lexer_core_defines.svh =====
// Assertion macros for the token lexer core.
`ifndef GRAPHQL_TOKEN_LEXER_CORE_DEFINES_SVH
`define GRAPHQL_TOKEN_LEXER_CORE_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define GTL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define GTL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/gtl_pkg.sv =====
// Shared types, token codes and keyword table for the token lexer.
package gtl_pkg;
  localparam int unsigned OffsetBits = 16;
  localparam int unsigned KwMaxLen = 12;
  localparam int unsigned KwCount = 28;
  localparam int unsigned ResMax = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = 2;
  localparam int unsigned KwLenW = 4;

  localparam logic [5:0] KUnknown = 6'd0;
  localparam logic [5:0] KIdent = 6'd1;
  localparam logic [5:0] KNumber = 6'd2;
  localparam logic [5:0] KVar = 6'd3;
  localparam logic [5:0] KDir = 6'd4;
  localparam logic [5:0] KString = 6'd5;
  localparam logic [5:0] KSymbol = 6'd6;
  localparam logic [5:0] KEllipsis = 6'd16;
  localparam logic [5:0] KKwBase = 6'd17;

  localparam logic [OffsetBits-1:0] PosLimit = {OffsetBits{1'b1}};

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
    tok_t       t2;
  } batch_t;

  function automatic logic [15:0] cap16(input logic [OffsetBits-1:0] x);
    return x[15:0];
  endfunction

  function automatic logic [OffsetBits-1:0] sat_inc(input logic [OffsetBits-1:0] x);
    return (x == PosLimit) ? x : x + 1'b1;
  endfunction

  function automatic logic [8*KwMaxLen-1:0] kw_text(input int unsigned k);
    logic [8*KwMaxLen-1:0] r;
    r = '0;
    unique case (k)
      0: r[15:0] = "no";
      1: r[15:0] = "di";
      2: r[23:0] = "tni";
      3: r[31:0] = "llun";
      4: r[31:0] = "eurt";
      5: r[31:0] = "epyt";
      6: r[31:0] = "mune";
      7: r[39:0] = "eslaf";
      8: r[39:0] = "taolf";
      9: r[39:0] = "yreuq";
      10: r[39:0] = "teg__";
      11: r[39:0] = "noinu";
      12: r[39:0] = "tupni";
      13: r[47:0] = "gnirts";
      14: r[47:0] = "ralacs";
      15: r[55:0] = "naeloob";
      16: r[55:0] = "sdnetxe";
      17: r[63:0] = "eteled__";
      18: r[63:0] = "amehcs__";
      19: r[63:0] = "etadpu__";
      20: r[63:0] = "etaerc__";
      21: r[63:0] = "noitatum";
      22: r[63:0] = "tnemgarf";
      23: r[71:0] = "ecafretni";
      24: r[71:0] = "evitcerid";
      25: r[79:0] = "stnemelpmi";
      26: r[79:0] = "emanepyt__";
      default: r[95:0] = "noitpircsbus";
    endcase
    return r;
  endfunction

  function automatic logic [KwLenW-1:0] kw_len(input int unsigned k);
    logic [KwLenW-1:0] r;
    unique case (k)
      0, 1: r = 4'd2;
      2: r = 4'd3;
      3, 4, 5, 6: r = 4'd4;
      7, 8, 9, 10, 11, 12: r = 4'd5;
      13, 14: r = 4'd6;
      15, 16: r = 4'd7;
      17, 18, 19, 20, 21, 22: r = 4'd8;
      23, 24: r = 4'd9;
      25, 26: r = 4'd10;
      default: r = 4'd12;
    endcase
    return r;
  endfunction
endpackage

// ===== src/gtl_front.sv =====
// Front end: byte-order mark, lexer state machine, token batch per byte.
module gtl_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             b_valid_o,
  input  logic             b_ready_i,
  output gtl_pkg::batch_t  b_o
);
  localparam logic [3:0] MIdle = 4'd0, MSlash = 4'd1, MDollar = 4'd2, MAt = 4'd3,
    MVar = 4'd4, MDir = 4'd5, MIdent = 4'd6, MNumber = 4'd7, MString = 4'd8,
    MStrEsc = 4'd9, MLine = 4'd10, MBlock = 4'd11, MBlockStar = 4'd12,
    MDot1 = 4'd13, MDot2 = 4'd14;
  localparam int unsigned OB = gtl_pkg::OffsetBits;

  logic [3:0] mode_q, mode_d;
  logic [OB-1:0] pos_q, pos_d, tstart_q, tstart_d, tlen_q, tlen_d;
  logic dec_q, dec_d, long_q, long_d, sq_q, sq_d;
  logic [1:0] bom_q, bom_d;
  logic [7:0] wbuf_q [gtl_pkg::KwMaxLen];
  logic wr_en;
  logic [3:0] wr_idx;
  gtl_pkg::tok_t toks [3];
  logic [1:0] cnt;
  logic fire;
  logic flush_ident;

  assign in_ready_o = b_ready_i;
  assign b_valid_o = in_valid_i;
  assign fire = in_valid_i && b_ready_i;

  function automatic logic is_id(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction
  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic [5:0] punct(input logic [7:0] c);
    logic [5:0] r;
    unique case (c)
      "{": r = 6'd7;
      "}": r = 6'd8;
      "(": r = 6'd9;
      ")": r = 6'd10;
      "[": r = 6'd11;
      "]": r = 6'd12;
      ":": r = 6'd13;
      ",": r = 6'd14;
      "!": r = 6'd15;
      default: r = 6'd0;
    endcase
    return r;
  endfunction
  function automatic logic is_sym(input logic [7:0] c);
    return c == "<" || c == ">" || c == "=" || c == "+" || c == "-" || c == "*" ||
           c == "&" || c == "|" || c == "^" || c == "~" || c == "%" || c == "?";
  endfunction

  logic [5:0] word_kind;
  always_comb begin
    logic [8*gtl_pkg::KwMaxLen-1:0] w;
    w = '0;
    word_kind = gtl_pkg::KIdent;
    for (int i = 0; i < int'(gtl_pkg::KwMaxLen); i++) begin
      if (tlen_q > OB'(i)) w[8*i +: 8] = wbuf_q[i];
    end
    if (!long_q && tlen_q <= OB'(gtl_pkg::KwMaxLen)) begin
      for (int k = 0; k < int'(gtl_pkg::KwCount); k++) begin
        if (tlen_q == OB'(gtl_pkg::kw_len(k)) && w == gtl_pkg::kw_text(k))
          word_kind = gtl_pkg::KKwBase + 6'(k);
      end
    end
  end

  always_comb begin
    logic [7:0] c;
    logic feed_en, idle_en;
    logic [OB-1:0] pos;
    mode_d = mode_q; pos_d = pos_q; tstart_d = tstart_q; tlen_d = tlen_q;
    dec_d = dec_q; long_d = long_q; sq_d = sq_q; bom_d = bom_q;
    wr_en = 1'b0; wr_idx = '0;
    cnt = '0;
    flush_ident = 1'b0;
    for (int i = 0; i < 3; i++) toks[i] = '0;
    c = in_byte_i; pos = pos_q;
    feed_en = 1'b0; idle_en = 1'b0;
    if (bom_q != 2'd3) begin
      if ((bom_q == 2'd0 && c == 8'hEF) || (bom_q == 2'd1 && c == 8'hBB) ||
          (bom_q == 2'd2 && c == 8'hBF)) begin
        bom_d = bom_q + 2'd1;
      end else begin
        for (int k = 0; k < 2; k++) begin
          if (bom_q > 2'(k)) begin
            toks[cnt] = '{gtl_pkg::KUnknown, 16'(k), 16'd1};
            cnt = cnt + 2'd1;
          end
        end
        bom_d = 2'd3;
        feed_en = 1'b1;
      end
    end else begin
      feed_en = 1'b1;
    end
    if (feed_en) begin
      idle_en = 1'b1;
      unique case (mode_q)
        MSlash: begin
          if (c == "/") begin mode_d = MLine; idle_en = 1'b0; end
          else if (c == "*") begin mode_d = MBlock; idle_en = 1'b0; end
          else begin
            toks[cnt] = '{gtl_pkg::KSymbol, gtl_pkg::cap16(tstart_q), 16'd1};
            cnt = cnt + 2'd1;
          end
        end
        MDollar, MAt: begin
          if (is_id(c)) begin
            mode_d = (mode_q == MDollar) ? MVar : MDir;
            tlen_d = OB'(2); idle_en = 1'b0;
          end else begin
            toks[cnt] = '{gtl_pkg::KSymbol, gtl_pkg::cap16(tstart_q), 16'd1};
            cnt = cnt + 2'd1;
          end
        end
        MVar, MDir: begin
          if (is_id(c)) begin tlen_d = gtl_pkg::sat_inc(tlen_q); idle_en = 1'b0; end
          else begin
            toks[cnt] = '{(mode_q == MVar) ? gtl_pkg::KVar : gtl_pkg::KDir,
                          gtl_pkg::cap16(tstart_q), gtl_pkg::cap16(tlen_q)};
            cnt = cnt + 2'd1;
          end
        end
        MIdent: begin
          if (is_id(c)) begin
            if (tlen_q < OB'(gtl_pkg::KwMaxLen)) begin
              wr_en = 1'b1; wr_idx = tlen_q[3:0];
            end else long_d = 1'b1;
            tlen_d = gtl_pkg::sat_inc(tlen_q); idle_en = 1'b0;
          end else begin
            toks[cnt] = '{word_kind, gtl_pkg::cap16(tstart_q), gtl_pkg::cap16(tlen_q)};
            cnt = cnt + 2'd1;
          end
        end
        MNumber: begin
          if (is_dig(c)) begin tlen_d = gtl_pkg::sat_inc(tlen_q); idle_en = 1'b0; end
          else if (c == "." && !dec_q) begin
            dec_d = 1'b1; tlen_d = gtl_pkg::sat_inc(tlen_q); idle_en = 1'b0;
          end else begin
            toks[cnt] = '{gtl_pkg::KNumber, gtl_pkg::cap16(tstart_q),
                          gtl_pkg::cap16(tlen_q)};
            cnt = cnt + 2'd1;
          end
        end
        MString: begin
          idle_en = 1'b0;
          tlen_d = gtl_pkg::sat_inc(tlen_q);
          if (c == "\\") mode_d = MStrEsc;
          else if (c == (sq_q ? 8'h27 : 8'h22)) begin
            toks[cnt] = '{gtl_pkg::KString, gtl_pkg::cap16(tstart_q),
                          gtl_pkg::cap16(gtl_pkg::sat_inc(tlen_q))};
            cnt = cnt + 2'd1;
            mode_d = MIdle;
          end
        end
        MStrEsc: begin
          idle_en = 1'b0; tlen_d = gtl_pkg::sat_inc(tlen_q); mode_d = MString;
        end
        MLine: begin idle_en = 1'b0; if (c == 8'h0A) mode_d = MIdle; end
        MBlock: begin idle_en = 1'b0; if (c == "*") mode_d = MBlockStar; end
        MBlockStar: begin
          idle_en = 1'b0;
          if (c == "/") mode_d = MIdle;
          else if (c != "*") mode_d = MBlock;
        end
        MDot1: begin
          if (c == ".") begin mode_d = MDot2; idle_en = 1'b0; end
          else begin
            toks[cnt] = '{gtl_pkg::KUnknown, gtl_pkg::cap16(tstart_q), 16'd1};
            cnt = cnt + 2'd1;
          end
        end
        MDot2: begin
          if (c == ".") begin
            toks[cnt] = '{gtl_pkg::KEllipsis, gtl_pkg::cap16(tstart_q), 16'd3};
            cnt = cnt + 2'd1; mode_d = MIdle; idle_en = 1'b0;
          end else begin
            toks[cnt] = '{gtl_pkg::KUnknown, gtl_pkg::cap16(tstart_q), 16'd1};
            toks[cnt+2'd1] = '{gtl_pkg::KUnknown,
                               gtl_pkg::cap16(gtl_pkg::sat_inc(tstart_q)), 16'd1};
            cnt = cnt + 2'd2;
          end
        end
        default: ;
      endcase
    end
    if (idle_en) begin
      mode_d = MIdle;
      if (!(c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D)) begin
        tstart_d = pos; tlen_d = OB'(1);
        if (c == "#") mode_d = MLine;
        else if (c == "/") mode_d = MSlash;
        else if (c == ".") mode_d = MDot1;
        else if (c == "$") mode_d = MDollar;
        else if (c == "@") mode_d = MAt;
        else if (punct(c) != 6'd0) begin
          toks[cnt] = '{punct(c), gtl_pkg::cap16(pos), 16'd1}; cnt = cnt + 2'd1;
        end else if (is_sym(c)) begin
          toks[cnt] = '{gtl_pkg::KSymbol, gtl_pkg::cap16(pos), 16'd1}; cnt = cnt + 2'd1;
        end else if (is_id(c) && !is_dig(c)) begin
          wr_en = 1'b1; wr_idx = '0; long_d = 1'b0; mode_d = MIdent;
        end else if (is_dig(c)) begin
          dec_d = 1'b0; mode_d = MNumber;
        end else if (c == 8'h22 || c == 8'h27) begin
          sq_d = (c == 8'h27); mode_d = MString;
        end else begin
          toks[cnt] = '{gtl_pkg::KUnknown, gtl_pkg::cap16(pos), 16'd1}; cnt = cnt + 2'd1;
        end
      end
    end
    if (in_last_i) begin
      // flush using the post-byte state
      if (bom_d != 2'd3) begin
        for (int k = 0; k < 2; k++) begin
          if (bom_d > 2'(k)) begin
            toks[cnt] = '{gtl_pkg::KUnknown, 16'(k), 16'd1};
            cnt = cnt + 2'd1;
          end
        end
      end
      unique case (mode_d)
        MSlash, MDollar, MAt: begin
          toks[cnt] = '{gtl_pkg::KSymbol, gtl_pkg::cap16(tstart_d), 16'd1};
          cnt = cnt + 2'd1;
        end
        MVar, MDir, MNumber, MString, MStrEsc: begin
          toks[cnt] = '{(mode_d == MVar) ? gtl_pkg::KVar :
                        (mode_d == MDir) ? gtl_pkg::KDir :
                        (mode_d == MNumber) ? gtl_pkg::KNumber : gtl_pkg::KString,
                        gtl_pkg::cap16(tstart_d), gtl_pkg::cap16(tlen_d)};
          cnt = cnt + 2'd1;
        end
        MIdent: begin
          toks[cnt] = '{gtl_pkg::KIdent, gtl_pkg::cap16(tstart_d),
                        gtl_pkg::cap16(tlen_d)};
          cnt = cnt + 2'd1;
          flush_ident = 1'b1;
        end
        MDot1: begin
          toks[cnt] = '{gtl_pkg::KUnknown, gtl_pkg::cap16(tstart_d), 16'd1};
          cnt = cnt + 2'd1;
        end
        MDot2: begin
          toks[cnt] = '{gtl_pkg::KUnknown, gtl_pkg::cap16(tstart_d), 16'd1};
          toks[cnt+2'd1] = '{gtl_pkg::KUnknown,
                             gtl_pkg::cap16(gtl_pkg::sat_inc(tstart_d)), 16'd1};
          cnt = cnt + 2'd2;
        end
        default: ;
      endcase
      mode_d = MIdle; pos_d = '0; tstart_d = '0; tlen_d = '0; dec_d = 1'b0;
      long_d = 1'b0; sq_d = 1'b0; bom_d = 2'd0;
    end else begin
      pos_d = gtl_pkg::sat_inc(pos_q);
    end
  end

  // identifier at end of document needs keyword check on the final buffer
  logic [5:0] last_kind;
  always_comb begin
    logic [8*gtl_pkg::KwMaxLen-1:0] w;
    logic [OB-1:0] ln;
    logic lg;
    w = '0;
    ln = (mode_q == MIdent && bom_q == 2'd3) ? gtl_pkg::sat_inc(tlen_q) : OB'(1);
    lg = (mode_q == MIdent && bom_q == 2'd3) ? long_d : 1'b0;
    for (int i = 0; i < int'(gtl_pkg::KwMaxLen); i++) begin
      if (wr_en && wr_idx == 4'(i)) w[8*i +: 8] = in_byte_i;
      else if (ln > OB'(i)) w[8*i +: 8] = wbuf_q[i];
    end
    last_kind = gtl_pkg::KIdent;
    if (!lg && ln <= OB'(gtl_pkg::KwMaxLen)) begin
      for (int k = 0; k < int'(gtl_pkg::KwCount); k++) begin
        if (ln == OB'(gtl_pkg::kw_len(k)) && w == gtl_pkg::kw_text(k))
          last_kind = gtl_pkg::KKwBase + 6'(k);
      end
    end
  end

  always_comb begin
    b_o.cnt = cnt;
    b_o.t0 = toks[0];
    b_o.t1 = toks[1];
    b_o.t2 = toks[2];
    if (flush_ident) begin
      if (cnt == 2'd1) b_o.t0.kind = last_kind;
      else if (cnt == 2'd2) b_o.t1.kind = last_kind;
      else b_o.t2.kind = last_kind;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && wr_en) wbuf_q[wr_idx] <= in_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MIdle; pos_q <= '0; tstart_q <= '0; tlen_q <= '0;
      dec_q <= 1'b0; long_q <= 1'b0; sq_q <= 1'b0; bom_q <= '0;
    end else if (fire) begin
      mode_q <= mode_d; pos_q <= pos_d; tstart_q <= tstart_d; tlen_q <= tlen_d;
      dec_q <= dec_d; long_q <= long_d; sq_q <= sq_d; bom_q <= bom_d;
    end
  end
endmodule

// ===== src/gtl_back.sv =====
// Back end: batch queue and token serializer onto the output stream.
module gtl_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             b_valid_i,
  output logic             b_ready_o,
  input  gtl_pkg::batch_t  b_i,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output gtl_pkg::tok_t    m_tok_o,
  output logic             m_last_o
);
  gtl_pkg::batch_t q_mem [gtl_pkg::QDepth];
  logic [gtl_pkg::QPtrW-1:0] wp_q, rp_q;
  logic [gtl_pkg::QPtrW:0] n_q;
  logic [1:0] sel_q;
  logic push, pop, head_ok;
  gtl_pkg::batch_t h;

  assign b_ready_o = n_q != (gtl_pkg::QPtrW+1)'(gtl_pkg::QDepth);
  assign push = b_valid_i && b_ready_o && b_i.cnt != 2'd0;
  assign h = q_mem[rp_q];
  assign head_ok = n_q != '0;
  assign m_valid_o = head_ok;
  assign m_last_o = (sel_q + 2'd1) == h.cnt;
  always_comb begin
    unique case (sel_q)
      2'd0: m_tok_o = h.t0;
      2'd1: m_tok_o = h.t1;
      default: m_tok_o = h.t2;
    endcase
  end
  assign pop = head_ok && m_ready_i && m_last_o;

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= b_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; n_q <= '0; sel_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      n_q <= n_q + (gtl_pkg::QPtrW+1)'(push) - (gtl_pkg::QPtrW+1)'(pop);
      if (head_ok && m_ready_i) sel_q <= m_last_o ? 2'd0 : sel_q + 2'd1;
    end
  end
endmodule

// ===== src/graphql_token_lexer_core.sv =====
// Top level of the streaming token lexer.
// channel | dir | tdata fields (low first)                | tuser / tlast
// s_axis  | in  | data_byte[7:0]                           | tuser = is_last
// m_axis  | out | token_kind[5:0] start_offset[21:6]       | tlast = last_of_run
//         |     | token_length[37:22], zero pad to 40 bits |
// One byte a cycle in while the back queue is not full; the front lexes
// it in the cycle it is accepted. The back queue holds four byte batches,
// sent a token at a time, so bytes that make several tokens slow the input.
// Reset clears all control state; it is asynchronous, active low.
`include "graphql_token_lexer_core_defines.svh"
module graphql_token_lexer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // token_kind, start_offset, token_length
  output logic        m_axis_tlast
);
  gtl_pkg::batch_t b;
  logic b_valid, b_ready;
  gtl_pkg::tok_t t;

  gtl_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_byte_i(s_axis_tdata), .in_last_i(s_axis_tuser),
    .b_valid_o(b_valid), .b_ready_i(b_ready), .b_o(b)
  );

  gtl_back u_back (
    .clk_i, .rst_ni,
    .b_valid_i(b_valid), .b_ready_o(b_ready), .b_i(b),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_tok_o(t), .m_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, t.len, t.start, t.kind};

  `GTL_ASSERT_IMP(a_kind_range, m_axis_tvalid, t.kind <= 6'd44, "token kind out of range")
  `GTL_ASSERT_IMP(a_len_nonzero, m_axis_tvalid, t.len != 16'd0, "zero token length")
  `GTL_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "valid dropped")
endmodule
